>>> hw/rtl/pcmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmd_pkg
// Shared types and constants of the pixel column min/max decimator.
// ----------------------------------------------------------------------------
package pcmd_pkg;

    localparam int COORD_W         = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_BREAK = 1'b1;

    localparam logic REG_STAIRCASE = 1'b0;

    typedef logic signed [COORD_W-1:0] t_coord;

    // one flushed column group, ready for expansion into vertices
    typedef struct packed {
        logic [COORD_W-1:0]        x;
        logic [3:0][COORD_W-1:0]   ys;
        logic [1:0]                last_idx;
        logic [COORD_W-1:0]        prev_y;
        logic                      open;
        logic                      ends;
    } t_desc;

endpackage
`default_nettype wire

>>> hw/rtl/pcmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmd_front
// Accepts items, merges points of one column, and queues flushed groups.
// ----------------------------------------------------------------------------
module pcmd_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire                   i_cmd,
    input  wire pcmd_pkg::t_coord i_column,
    input  wire pcmd_pkg::t_coord i_row,
    input  wire                   i_q_full,
    output logic                  o_push,
    output pcmd_pkg::t_desc       o_desc
);
    import pcmd_pkg::*;

    t_coord r_col, r_first, r_min, r_max, r_latest, r_prev_y;
    logic   r_nonempty, r_line_open;

    logic   accept, same_col, flush;
    logic [1:0] k;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign same_col = r_nonempty && (r_col == i_column);
    assign flush    = accept && r_nonempty && ((i_cmd == CMD_BREAK) || !same_col);
    assign o_push   = flush;

    always_comb begin
        k = 2'd0;
        o_desc.ys = {4{r_first}};
        if (r_min != r_first) begin
            k = k + 2'd1;
            o_desc.ys[k] = r_min;
        end
        if (r_max != r_min) begin
            k = k + 2'd1;
            o_desc.ys[k] = r_max;
        end
        if (r_max != r_latest) begin
            k = k + 2'd1;
            o_desc.ys[k] = r_latest;
        end
        o_desc.x        = r_col;
        o_desc.last_idx = k;
        o_desc.prev_y   = r_prev_y;
        o_desc.open     = r_line_open;
        o_desc.ends     = (i_cmd == CMD_BREAK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty  <= 1'b0;
            r_line_open <= 1'b0;
            r_prev_y    <= '0;
        end else if (accept) begin
            if (flush) begin
                r_prev_y    <= r_latest;
                r_line_open <= 1'b1;
            end
            if (i_cmd == CMD_BREAK) begin
                r_nonempty  <= 1'b0;
                r_line_open <= 1'b0;
            end else begin
                r_nonempty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd == CMD_POINT)) begin
            if (same_col) begin
                r_latest <= i_row;
                if (i_row < r_min) begin
                    r_min <= i_row;
                end
                if (i_row > r_max) begin
                    r_max <= i_row;
                end
            end else begin
                r_col    <= i_column;
                r_first  <= i_row;
                r_min    <= i_row;
                r_max    <= i_row;
                r_latest <= i_row;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/pcmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmd_queue
// Short FIFO of flushed groups between the front and back ends.
// ----------------------------------------------------------------------------
module pcmd_queue #(
    parameter int DEPTH = pcmd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire pcmd_pkg::t_desc  i_desc,
    input  wire                   i_pop,
    output pcmd_pkg::t_desc       o_head,
    output logic                  o_full,
    output logic                  o_empty
);
    import pcmd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/pcmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmd_back
// Expands queued groups into vertices and step corners, one item a cycle while not stalled.
// ----------------------------------------------------------------------------
module pcmd_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_staircase,
    input  wire                   i_q_empty,
    input  wire pcmd_pkg::t_desc  i_desc,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_ready,
    output pcmd_pkg::t_coord      o_out_x,
    output pcmd_pkg::t_coord      o_out_y,
    output logic                  o_ends_line,
    output logic                  o_last
);
    import pcmd_pkg::*;

    logic [1:0] r_v;
    logic       r_c, r_fresh, r_valid;
    t_coord     r_x, r_y;
    logic       r_ends, r_last;

    logic       take, advance, corner, final_v;
    logic [1:0] v_prev;

    assign take    = !r_valid || i_ready;
    assign advance = take && !i_q_empty;
    assign corner  = r_fresh ? (i_staircase && i_desc.open) : r_c;
    assign final_v = (r_v == i_desc.last_idx);
    assign v_prev  = r_v - 2'd1;
    assign o_pop   = advance && !corner && final_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_v     <= '0;
            r_c     <= 1'b0;
            r_fresh <= 1'b1;
        end else begin
            if (take) begin
                r_valid <= !i_q_empty;
            end
            if (advance) begin
                if (corner) begin
                    r_c     <= 1'b0;
                    r_fresh <= 1'b0;
                end else if (final_v) begin
                    r_v     <= '0;
                    r_c     <= 1'b0;
                    r_fresh <= 1'b1;
                end else begin
                    r_v     <= r_v + 2'd1;
                    r_c     <= i_staircase;
                    r_fresh <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x <= i_desc.x;
            if (corner) begin
                r_y    <= (r_v == 2'd0) ? i_desc.prev_y : i_desc.ys[v_prev];
                r_ends <= 1'b0;
                r_last <= 1'b0;
            end else begin
                r_y    <= i_desc.ys[r_v];
                r_ends <= final_v && i_desc.ends;
                r_last <= final_v;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_x     = r_x;
    assign o_out_y     = r_y;
    assign o_ends_line = r_ends;
    assign o_last      = r_last;

endmodule
`default_nettype wire

>>> hw/rtl/pixel_column_minmax_decimator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_column_minmax_decimator
// Reduces pixel-space plot points to polyline vertices per pixel column.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while its group queue has room; a
// point in the current column merges in that cycle and gives no result. A
// column change or a break queues the finished group, and the back end then
// emits its 1 to 4 vertices, plus in staircase mode one step corner before
// each vertex but the first of a line, at one result per cycle from its
// output register while the output is not stalled, so a group yields
// between 1 and 8 results. The queue holds QUEUE_DEPTH groups.
module pixel_column_minmax_decimator #(
    parameter int QUEUE_DEPTH = pcmd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [pcmd_pkg::ADDR_W-1:0]      paddr,
    input  wire [pcmd_pkg::DATA_W-1:0]      pwdata,
    output logic [pcmd_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire                             i_cmd,
    input  wire pcmd_pkg::t_coord           i_column,
    input  wire pcmd_pkg::t_coord           i_row,
    output logic                            o_valid,
    input  wire                             i_ready,
    output pcmd_pkg::t_coord                o_out_x,
    output pcmd_pkg::t_coord                o_out_y,
    output logic                            o_ends_line,
    output logic                            o_last
);
    import pcmd_pkg::*;

    logic  r_staircase;
    logic  q_push, q_pop, q_full, q_empty;
    t_desc push_desc, head_desc;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STAIRCASE) ? {{(DATA_W-1){1'b0}}, r_staircase} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_staircase <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STAIRCASE)) begin
            r_staircase <= pwdata[0];
        end
    end

    pcmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .i_column (i_column),
        .i_row    (i_row),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_desc   (push_desc)
    );

    pcmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_head  (head_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pcmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_staircase (r_staircase),
        .i_q_empty   (q_empty),
        .i_desc      (head_desc),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_ends_line (o_ends_line),
        .o_last      (o_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("group pushed into full queue");

    a_ends_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ends_line) |-> o_last)
        else $error("line end on a non-final item");

    a_pop_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
